>>> rtl/delayed_error_damping_with_still_gains_core_macros.svh
// assertion macros for the delayed error damping core
`ifndef DELAYED_ERROR_DAMPING_WITH_STILL_GAINS_CORE_MACROS_SVH
`define DELAYED_ERROR_DAMPING_WITH_STILL_GAINS_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DEDSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DEDSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dedsg_pkg.sv
// types and constants shared by the delayed error damping core
package dedsg_pkg;

    localparam int DELAY_DEPTH       = 1024;
    localparam int DELAY_AW          = $clog2(DELAY_DEPTH);
    localparam int STILL_COUNT_WIDTH = 16;

    localparam logic [STILL_COUNT_WIDTH-1:0] STILL_MAX = '1;
    localparam logic [31:0] GATE_LIMIT_Q824 = 32'd17;
    localparam int GAIN_FRAC = 15;

    typedef enum logic [2:0] {
        CFG_DELAY_SAMPLES  = 3'd0,
        CFG_DAMPING_GAIN   = 3'd1,
        CFG_DAMPING_ENABLE = 3'd2,
        CFG_STILL_VELOCITY = 3'd3,
        CFG_STILL_TICKS    = 3'd4,
        CFG_P_NORMAL       = 3'd5,
        CFG_P_LOW          = 3'd6,
        CFG_I_NORMAL       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] commanded_position;
        logic signed [31:0] measured_position;
        logic signed [31:0] velocity;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] dest_offset;
        logic        [31:0] p_gain;
        logic        [31:0] i_gain;
        logic               held_still;
    } t_out_item;

    // what travels with an item while its delayed error is read
    typedef struct packed {
        logic signed [31:0] err;
        logic               fwd;
        logic               rd_ok;
        logic               gate;
        logic        [31:0] p_gain;
        logic        [31:0] i_gain;
        logic               held;
    } t_rd_stage;

endpackage

>>> rtl/delayed_error_damping_with_still_gains_core.sv
// Delayed error damping core: delay memory, offset scaling and anti-dither gains.
//
// Input channel: i_in_valid / o_in_stall with i_in_data, one transfer per servo tick.
// Output channel: o_out_valid / i_out_stall with o_out_data, one result per tick.
// Config channel: i_cfg_valid / o_cfg_ready (always high), register index and data;
// write only while no tick is in flight.
// Path: the memory read and the tick's fields are registered in the read stage at the
// transfer edge, and the scaling multiply feeds the output register.
// Throughput: one tick per cycle unless stalled; the single-port write plus one read of
// the delay memory per tick sets that figure; a delay of zero is forwarded around it.
// Reset: config registers take their defaults, the write pointer and fill count
// clear, the still counter saturates. The delay memory is not swept; entries not yet
// written since reset read as zero through the fill count, so a tick is taken at once.
// Stall: when i_out_stall holds a full output register, a full read stage stays full
// and o_in_stall rises; the input is taken again once the output moves.
module delayed_error_damping_with_still_gains_core
    import dedsg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

`include "delayed_error_damping_with_still_gains_core_macros.svh"

    // configuration registers
    logic [9:0]  r_delay;
    logic [14:0] r_gain;
    logic        r_enable;
    logic [30:0] r_still_vel;
    logic [15:0] r_still_ticks;
    logic [31:0] r_p_normal;
    logic [31:0] r_p_low;
    logic [31:0] r_i_normal;

    // tick state
    logic [DELAY_AW-1:0]          r_wr_idx;
    logic [DELAY_AW:0]            r_fill;
    logic [STILL_COUNT_WIDTH-1:0] r_still_cnt;
    logic [31:0]                  r_held_i;

    logic signed [31:0] mem [DELAY_DEPTH];
    logic signed [31:0] r_mem_q;

    logic      r_s1_v;
    t_rd_stage r_s1;
    logic      r_out_v;
    t_out_item r_out;

    logic                         in_accept;
    logic                         s1_adv;
    logic signed [32:0]           diff;
    logic signed [31:0]           err;
    logic [DELAY_AW-1:0]          delay_mod;
    logic [DELAY_AW-1:0]          rd_idx;
    logic [31:0]                  vel_mag;
    logic [STILL_COUNT_WIDTH-1:0] n_still_cnt;
    logic                         held;
    logic [31:0]                  i_out;
    t_rd_stage                    n_s1;
    logic signed [31:0]           delayed;
    logic signed [47:0]           product;
    logic signed [47:0]           scaled;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay       <= 10'd61;
            r_gain        <= 15'd8192;
            r_enable      <= 1'b0;
            r_still_vel   <= 31'd100;
            r_still_ticks <= 16'd333;
            r_p_normal    <= 32'd838861;
            r_p_low       <= 32'd0;
            r_i_normal    <= 32'd13422;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DELAY_SAMPLES:  r_delay       <= i_cfg_data[9:0];
                CFG_DAMPING_GAIN:   r_gain        <= i_cfg_data[14:0];
                CFG_DAMPING_ENABLE: r_enable      <= i_cfg_data[0];
                CFG_STILL_VELOCITY: r_still_vel   <= i_cfg_data[30:0];
                CFG_STILL_TICKS:    r_still_ticks <= i_cfg_data[15:0];
                CFG_P_NORMAL:       r_p_normal    <= i_cfg_data;
                CFG_P_LOW:          r_p_low       <= i_cfg_data;
                CFG_I_NORMAL:       r_i_normal    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign s1_adv     = !r_out_v || !i_out_stall;
    assign o_in_stall = r_s1_v && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    // error with saturation
    always_comb begin
        diff = 33'(i_in_data.commanded_position) - 33'(i_in_data.measured_position);
        if (diff[32] != diff[31]) begin
            err = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            err = diff[31:0];
        end
    end

    assign delay_mod = DELAY_AW'(r_delay);
    assign rd_idx    = r_wr_idx - delay_mod;

    // anti-dither counter and gain choice
    always_comb begin
        vel_mag = i_in_data.velocity[31] ? (32'd0 - i_in_data.velocity)
                                         : i_in_data.velocity;
        if (vel_mag > {1'b0, r_still_vel}) begin
            n_still_cnt = '0;
        end else if (r_still_cnt != STILL_MAX) begin
            n_still_cnt = r_still_cnt + 1'b1;
        end else begin
            n_still_cnt = r_still_cnt;
        end
        held  = 32'(n_still_cnt) > 32'(r_still_ticks);
        i_out = held ? 32'd0 : r_i_normal;

        n_s1.err    = err;
        n_s1.fwd    = (delay_mod == '0);
        // entry not yet written since reset reads as zero
        n_s1.rd_ok  = (DELAY_AW + 1)'(delay_mod) <= r_fill;
        n_s1.gate   = !r_enable || (r_held_i < GATE_LIMIT_Q824);
        n_s1.p_gain = held ? r_p_low : r_p_normal;
        n_s1.i_gain = i_out;
        n_s1.held   = held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_still_cnt <= STILL_MAX;
            r_held_i    <= '0;
        end else if (in_accept) begin
            r_wr_idx    <= r_wr_idx + 1'b1;
            r_still_cnt <= n_still_cnt;
            r_held_i    <= i_out;
            if (r_fill != (DELAY_AW + 1)'(DELAY_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // delay memory: one write and one read per transfer, read data held while stalled
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            mem[r_wr_idx] <= err;
            r_mem_q       <= mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= n_s1;
        end
    end

    // scale by the Q0.15 gain, floor by arithmetic shift
    always_comb begin
        if (r_s1.fwd) begin
            delayed = r_s1.err;
        end else if (r_s1.rd_ok) begin
            delayed = r_mem_q;
        end else begin
            delayed = '0;
        end
        product = 48'(delayed) * 48'(signed'({1'b0, r_gain}));
        scaled  = product >>> GAIN_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_v) begin
            r_out.dest_offset <= r_s1.gate ? 32'sd0 : scaled[31:0];
            r_out.p_gain      <= r_s1.p_gain;
            r_out.i_gain      <= r_s1.i_gain;
            r_out.held_still  <= r_s1.held;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `DEDSG_ASSERT_NOW(a_stall_only_when_blocked, i_clk, i_rst_n, o_in_stall,
        r_s1_v && o_out_valid && i_out_stall, "input stalled without a blocked output")
    `DEDSG_ASSERT_NEXT(a_accept_fills_read_stage, i_clk, i_rst_n, in_accept,
        r_s1_v, "accepted tick did not reach the read stage")
    `DEDSG_ASSERT_NOW(a_output_from_read_stage, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_s1_v), "result appeared without a tick in the read stage")
    `DEDSG_ASSERT_NOW(a_fill_bounded, i_clk, i_rst_n, 1'b1,
        r_fill <= (DELAY_AW + 1)'(DELAY_DEPTH), "fill count ran past the memory depth")

endmodule

>>> tb/sv/delayed_error_damping_with_still_gains_core_tb.sv
// testbench for the delayed error damping core: directed and random servo ticks vs a predictor
module delayed_error_damping_with_still_gains_core_tb;
    import dedsg_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 154;
    localparam int REG_WIDTH [8]   = '{10, 15, 1, 31, 16, 32, 32, 32};
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    delayed_error_damping_with_still_gains_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // damping predictor: register copies and tick state
    logic [9:0]         delay_cfg;
    logic [14:0]        gain_cfg;
    logic               enable_cfg;
    logic [30:0]        still_vel_cfg;
    logic [15:0]        still_ticks_cfg;
    logic [31:0]        p_normal_cfg;
    logic [31:0]        p_low_cfg;
    logic [31:0]        i_normal_cfg;
    logic signed [31:0] error_history [DELAY_DEPTH];
    logic [9:0]         history_wr;
    logic [15:0]        still_count;
    logic [31:0]        prev_i_gain;

    t_in_item    pending_ticks [$];
    t_out_item   expected_results [$];
    logic [31:0] reg_values [8];
    int          idle_pct;
    int          stall_pct;
    logic        in_taken;
    int          mismatches;
    int          idle_cycles;

    task automatic clear_predictor();
        delay_cfg       = 10'd61;
        gain_cfg        = 15'd8192;
        enable_cfg      = 1'b0;
        still_vel_cfg   = 31'd100;
        still_ticks_cfg = 16'd333;
        p_normal_cfg    = 32'd838861;
        p_low_cfg       = 32'd0;
        i_normal_cfg    = 32'd13422;
        for (int k = 0; k < DELAY_DEPTH; k++) error_history[k] = '0;
        history_wr  = '0;
        still_count = STILL_MAX;
        prev_i_gain = '0;
    endtask

    function automatic t_out_item predict_tick(input t_in_item t);
        longint             diff;
        longint             product;
        longint             vel_mag;
        logic signed [31:0] delayed;
        logic [9:0]         rd;
        logic               held;
        t_out_item          r;
        diff = longint'(t.commanded_position) - longint'(t.measured_position);
        if (diff > longint'(POS_MAX)) diff = longint'(POS_MAX);
        if (diff < longint'(POS_MIN)) diff = longint'(POS_MIN);
        // error goes in before the read so a zero delay sees this tick
        error_history[history_wr] = diff[31:0];
        rd = history_wr - delay_cfg;
        delayed = error_history[rd];
        history_wr = history_wr + 10'd1;
        product = longint'(delayed) * longint'(gain_cfg);
        product = product >>> GAIN_FRAC;
        r.dest_offset = product[31:0];
        if (!enable_cfg || prev_i_gain < GATE_LIMIT_Q824) r.dest_offset = '0;
        vel_mag = longint'(t.velocity);
        if (vel_mag < 0) vel_mag = -vel_mag;
        if (vel_mag > longint'(still_vel_cfg)) still_count = '0;
        else if (still_count != STILL_MAX) still_count = still_count + 16'd1;
        held = still_count > still_ticks_cfg;
        r.p_gain     = held ? p_low_cfg : p_normal_cfg;
        r.i_gain     = held ? 32'd0 : i_normal_cfg;
        r.held_still = held;
        prev_i_gain  = r.i_gain;
        return r;
    endfunction

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: offset %0d p %h i %h held %b",
                         got.dest_offset, got.p_gain, got.i_gain, got.held_still);
        end else begin
            want = expected_results.pop_front();
            if (got.dest_offset !== want.dest_offset || got.p_gain !== want.p_gain ||
                got.i_gain !== want.i_gain || got.held_still !== want.held_still) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected offset %0d p %h i %h held %b,",
                              " got offset %0d p %h i %h held %b"},
                             want.dest_offset, want.p_gain, want.i_gain, want.held_still,
                             got.dest_offset, got.p_gain, got.i_gain, got.held_still);
            end
        end
    endtask

    // monitor: register writes, input transfers into the predictor, result checks, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_predictor();
            in_taken    <= 1'b0;
            idle_cycles <= 0;
        end else begin
            in_taken <= i_in_valid && !o_in_stall;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DELAY_SAMPLES:  delay_cfg       = i_cfg_data[9:0];
                    CFG_DAMPING_GAIN:   gain_cfg        = i_cfg_data[14:0];
                    CFG_DAMPING_ENABLE: enable_cfg      = i_cfg_data[0];
                    CFG_STILL_VELOCITY: still_vel_cfg   = i_cfg_data[30:0];
                    CFG_STILL_TICKS:    still_ticks_cfg = i_cfg_data[15:0];
                    CFG_P_NORMAL:       p_normal_cfg    = i_cfg_data;
                    CFG_P_LOW:          p_low_cfg       = i_cfg_data;
                    CFG_I_NORMAL:       i_normal_cfg    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) expected_results.push_back(predict_tick(i_in_data));
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // tick driver: a new transfer is offered only once the previous one went through
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_ticks.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    task automatic push_tick(input logic signed [31:0] cmd, input logic signed [31:0] meas,
                             input logic signed [31:0] vel);
        t_in_item t;
        t.commanded_position = cmd;
        t.measured_position  = meas;
        t.velocity           = vel;
        pending_ticks.push_back(t);
    endtask

    // quiet ticks keep |velocity| within the threshold so the still counter can run up
    function automatic t_in_item random_tick(input logic quiet);
        t_in_item           t;
        logic signed [31:0] edges [4];
        int                 lim;
        edges = '{POS_MAX, POS_MIN, 32'sd0, -32'sd1};
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                t.measured_position  = $urandom();
                t.commanded_position = $urandom();
            end
            4, 5, 6, 7: begin
                t.measured_position  = $urandom();
                t.commanded_position = t.measured_position + (int'($urandom_range(4000)) - 2000);
            end
            default: begin
                t.measured_position  = edges[$urandom_range(3)];
                t.commanded_position = edges[$urandom_range(3)];
            end
        endcase
        if (quiet) begin
            lim = (still_vel_cfg > 31'd1000) ? 1000 : int'(still_vel_cfg);
            t.velocity = int'($urandom_range(2 * lim)) - lim;
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: t.velocity = int'($urandom_range(300)) - 150;
                6, 7:             t.velocity = $urandom();
                8:                t.velocity = edges[$urandom_range(3)];
                default: begin
                    // right at the threshold or one past it
                    t.velocity = {1'b0, still_vel_cfg} + $urandom_range(1);
                    if ($urandom_range(1) == 1) t.velocity = -t.velocity;
                end
            endcase
        end
        return t;
    endfunction

    task automatic load_registers();
        logic [31:0] v;
        for (int k = 0; k < 8; k++) begin
            v = reg_values[k];
            // unused upper bits carry junk, the block keeps only the field width
            if (REG_WIDTH[k] < 32) v = v | ($urandom() << REG_WIDTH[k]);
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= v;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_settled();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic fill_random(input int count);
        int   seg;
        logic quiet;
        int   n;
        n = 0;
        while (n < count) begin
            seg   = $urandom_range(5, 30);
            quiet = 1'($urandom_range(1));
            for (int j = 0; j < seg && n < count; j++) begin
                pending_ticks.push_back(random_tick(quiet));
                n++;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        mismatches  = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero delay, full gain, short still time, gate just open
        reg_values = '{10'd0, 15'd32767, 1'b1, 31'd100, 16'd3,
                       32'hFFFF_FFFF, 32'h1234_5678, 32'd17};
        load_registers();
        push_tick(0, 0, 0);                 // still from reset, gated
        push_tick(POS_MAX, POS_MIN, POS_MIN); // positive overflow, full negative speed
        push_tick(POS_MIN, POS_MAX, 101);   // negative overflow
        push_tick(-5, 0, -101);             // floor of a negative product
        push_tick(5, 0, 100);               // speed right at the threshold
        push_tick(POS_MAX, 0, -100);
        push_tick(0, 1, 0);
        push_tick(7, 0, 0);                 // count passes still_ticks
        push_tick(-7, 0, 0);                // gate closed by the zero i gain
        push_tick(1, 0, POS_MAX);
        push_tick(-1, 0, -2);
        wait_settled();

        // longest delay, threshold at its top, low gains never chosen
        reg_values = '{10'd1023, 15'd1, 1'b1, 31'h7FFF_FFFF, 16'hFFFF,
                       32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        load_registers();
        idle_pct  = 13;
        stall_pct = 13;
        push_tick(POS_MAX, -1, POS_MAX);
        push_tick(POS_MIN, 1, POS_MIN);
        push_tick(123456, -654321, 0);
        push_tick(-1, -1, -1);
        push_tick(-98765, 4321, 32'sh4000_0000);
        wait_settled();

        // damping off, zero gain and threshold, immediate still
        reg_values = '{10'd2, 15'd0, 1'b0, 31'd0, 16'd0,
                       32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd16};
        load_registers();
        idle_pct  = 0;
        stall_pct = 0;
        push_tick(1000, 0, 0);
        push_tick(-1000, 0, 1);
        push_tick(3, 2, 0);
        push_tick(0, 0, -1);
        wait_settled();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(3))
                0:       reg_values[CFG_DELAY_SAMPLES] = 0;
                1:       reg_values[CFG_DELAY_SAMPLES] = 1023;
                2:       reg_values[CFG_DELAY_SAMPLES] = $urandom_range(1, 8);
                default: reg_values[CFG_DELAY_SAMPLES] = $urandom_range(1023);
            endcase
            case ($urandom_range(3))
                0:       reg_values[CFG_DAMPING_GAIN] = 0;
                1:       reg_values[CFG_DAMPING_GAIN] = 32767;
                default: reg_values[CFG_DAMPING_GAIN] = $urandom_range(32767);
            endcase
            reg_values[CFG_DAMPING_ENABLE] = 32'($urandom_range(3) != 0);
            case ($urandom_range(5))
                0:       reg_values[CFG_STILL_VELOCITY] = 0;
                1:       reg_values[CFG_STILL_VELOCITY] = 32'h7FFF_FFFF;
                default: reg_values[CFG_STILL_VELOCITY] = $urandom_range(200);
            endcase
            case ($urandom_range(4))
                0:       reg_values[CFG_STILL_TICKS] = 0;
                1:       reg_values[CFG_STILL_TICKS] = $urandom_range(65534, 65535);
                default: reg_values[CFG_STILL_TICKS] = $urandom_range(1, 12);
            endcase
            reg_values[CFG_P_NORMAL] = $urandom();
            reg_values[CFG_P_LOW]    = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom();
            case ($urandom_range(4))
                0:       reg_values[CFG_I_NORMAL] = 0;
                1:       reg_values[CFG_I_NORMAL] = $urandom_range(16, 17);
                2:       reg_values[CFG_I_NORMAL] = $urandom();
                default: reg_values[CFG_I_NORMAL] = $urandom_range(17, 50000);
            endcase
            load_registers();
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            // the sender runs dry halfway and waits for every result
            fill_random(TICKS_PER_PHASE / 2);
            wait_settled();
            fill_random(TICKS_PER_PHASE - TICKS_PER_PHASE / 2);
            wait_settled();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dedsg_pkg.sv
rtl/delayed_error_damping_with_still_gains_core.sv
tb/sv/delayed_error_damping_with_still_gains_core_tb.sv
